// ===== hdl/rpf_pkg.sv =====
package rpf_pkg;

    localparam logic [7:0] BYTE_PREAMBLE    = 8'hAA;
    localparam logic [7:0] BYTE_SYNC        = 8'h2D;
    localparam logic [7:0] BYTE_TRAILER     = 8'hAA;
    localparam logic [7:0] NETWORK_ID_RESET = 8'hD4;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam int          ADDR_W          = 2;
    localparam logic [1:0]  ADDR_NETWORK_ID = 2'd0;

    // Step counter for preamble and trailer runs of up to eight bytes.
    localparam int CNT_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        JOB_START = 2'd0,
        JOB_DATA  = 2'd1,
        JOB_STRAY = 2'd2
    } job_kind_t;

    // One classified word handed from the front end to the byte sequencer.
    // close is set when this job ends the frame; the trailer, if configured, follows it.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] value;
        logic       close;
    } job_t;

endpackage

// ===== hdl/rpf_front.sv =====
module rpf_front
    import rpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       command,
    input  logic [7:0] payload_length,
    input  logic [7:0] data_byte,
    output job_t       job
);

    logic       frame_open_reg;
    logic       frame_open_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;

    always_comb
    begin
        job             = '{kind: JOB_STRAY, value: 8'd0, close: 1'b0};
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        if (command == CMD_START)
        begin
            job.kind  = JOB_START;
            job.value = payload_length;
            job.close = (payload_length == 8'd0);
            if (accept)
            begin
                frame_open_next = (payload_length != 8'd0);
                bytes_left_next = payload_length;
            end
        end
        else if (frame_open_reg)
        begin
            job.kind  = JOB_DATA;
            job.value = data_byte;
            job.close = (bytes_left_reg == 8'd1);
            if (accept)
            begin
                bytes_left_next = bytes_left_reg - 8'd1;
                frame_open_next = (bytes_left_reg != 8'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ===== hdl/rpf_queue.sv =====
module rpf_queue
    import rpf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign empty = (count_reg == QCNT_W'(0));
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/rpf_back.sv =====
module rpf_back
    import rpf_pkg::*;
#(
    parameter int PREAMBLE_COUNT = 3,
    parameter int TRAILER_COUNT  = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       q_empty,
    output logic       pop,
    input  logic [7:0] network_id,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       frame_done,
    output logic       stray_byte
);

    localparam logic [CNT_W-1:0] PRE_LAST = CNT_W'(PREAMBLE_COUNT - 1);
    localparam logic [CNT_W-1:0] TRL_LAST = CNT_W'((TRAILER_COUNT == 0) ? 0 : TRAILER_COUNT - 1);
    localparam logic             HAS_TRAILER = (TRAILER_COUNT != 0);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PRE   = 8'b0000_0010,
        ST_SYNC  = 8'b0000_0100,
        ST_NID   = 8'b0000_1000,
        ST_LEN   = 8'b0001_0000,
        ST_DATA  = 8'b0010_0000,
        ST_TRAIL = 8'b0100_0000,
        ST_STRAY = 8'b1000_0000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    state_t           step_state;
    state_t           first_state;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] step_cnt;
    job_t             job_reg;
    job_t             job_next;

    logic       cur_last;
    logic       cur_done;
    logic       cur_stray;
    logic [7:0] cur_byte;
    logic       busy;
    logic       advance;
    logic       emit;
    logic       load;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       done_reg;
    logic       stray_reg;

    // Byte for the current step and where the sequence goes after it.
    always_comb
    begin
        cur_byte   = 8'd0;
        cur_last   = 1'b0;
        cur_done   = 1'b0;
        cur_stray  = 1'b0;
        step_state = state_reg;
        step_cnt   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_state = ST_IDLE;
            end
            ST_PRE:
            begin
                cur_byte = BYTE_PREAMBLE;
                if (cnt_reg == PRE_LAST)
                begin
                    step_state = ST_SYNC;
                    step_cnt   = '0;
                end
                else
                begin
                    step_cnt = cnt_reg + CNT_W'(1);
                end
            end
            ST_SYNC:
            begin
                cur_byte   = BYTE_SYNC;
                step_state = ST_NID;
            end
            ST_NID:
            begin
                cur_byte   = network_id;
                step_state = ST_LEN;
            end
            ST_LEN, ST_DATA:
            begin
                cur_byte = (state_reg == ST_LEN) ? job_reg.value + 8'd1 : job_reg.value;
                step_cnt = '0;
                if (job_reg.close && HAS_TRAILER)
                begin
                    step_state = ST_TRAIL;
                end
                else
                begin
                    cur_last = 1'b1;
                    cur_done = job_reg.close;
                end
            end
            ST_TRAIL:
            begin
                cur_byte = BYTE_TRAILER;
                if (cnt_reg == TRL_LAST)
                begin
                    cur_last = 1'b1;
                    cur_done = 1'b1;
                end
                else
                begin
                    step_cnt = cnt_reg + CNT_W'(1);
                end
            end
            ST_STRAY:
            begin
                cur_last  = 1'b1;
                cur_stray = 1'b1;
            end
            default:
            begin
                step_state = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (head.kind)
            JOB_START: first_state = ST_PRE;
            JOB_DATA:  first_state = ST_DATA;
            JOB_STRAY: first_state = ST_STRAY;
            default:   first_state = ST_STRAY;
        endcase
    end

    assign busy    = (state_reg != ST_IDLE);
    assign advance = !out_valid_reg || out_ready;
    assign emit    = busy && advance;
    assign load    = !q_empty && (!busy || (emit && cur_last));
    assign pop     = load;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        job_next   = job_reg;
        if (load)
        begin
            state_next = first_state;
            cnt_next   = '0;
            job_next   = head;
        end
        else if (emit)
        begin
            state_next = cur_last ? ST_IDLE : step_state;
            cnt_next   = step_cnt;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= cur_last;
            done_reg     <= cur_done;
            stray_reg    <= cur_stray;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign frame_done  = done_reg;
    assign stray_byte  = stray_reg;

endmodule

// ===== hdl/radio_packet_framer_unit.sv =====
// Packet framer for a radio transmitter FIFO. A start word emits PREAMBLE_COUNT bytes of
// 0xAA, the sync byte 0x2D, the network id and the length plus one; each payload word inside
// an open frame emits its byte, and the closing payload word (or a start of length zero) adds
// TRAILER_COUNT bytes of 0xAA with frame_done on the last. A payload word with no frame open
// gives one flagged result and sends nothing. The front end classifies each word in the cycle
// it is taken and files it in a four-entry queue; the back end emits exactly one byte per cycle
// while it holds a word and the output register is free. A payload word yields one byte, a
// start PREAMBLE_COUNT + 3, plus TRAILER_COUNT where the frame closes. Payload words stream at
// one per cycle unless out_ready holds them back. A taken word is registered in the queue, then
// in the back-end state, then in the output register. in_ready falls only when the queue is full.
module radio_packet_framer_unit
    import rpf_pkg::*;
#(
    parameter int PREAMBLE_COUNT = 3,
    parameter int TRAILER_COUNT  = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [7:0]        payload_length,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              frame_done,
    output logic              stray_byte
);

    logic [7:0] network_id_reg;
    logic       cfg_write;
    logic       accept;
    logic       q_empty;
    logic       q_full;
    logic       pop;
    job_t       new_job;
    job_t       head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_NETWORK_ID);
    assign prdata    = (paddr == ADDR_NETWORK_ID) ? {24'd0, network_id_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            network_id_reg <= NETWORK_ID_RESET;
        end
        else if (cfg_write)
        begin
            network_id_reg <= pwdata[7:0];
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    rpf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .command        (command),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .job            (new_job)
    );

    rpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (new_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    rpf_back #(
        .PREAMBLE_COUNT (PREAMBLE_COUNT),
        .TRAILER_COUNT  (TRAILER_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .network_id  (network_id_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .frame_done  (frame_done),
        .stray_byte  (stray_byte)
    );

    // The end of a frame is always the end of the word that caused it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame_done without last_of_run");

    // A stray word stands alone and carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stray_byte |-> last_of_run && !frame_done && (out_byte == 8'd0))
        else $error("malformed stray result");

    // With a trailer configured, a frame always ends on a trailer byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done && (TRAILER_COUNT != 0) |-> out_byte == BYTE_TRAILER)
        else $error("frame closed on a non-trailer byte");

    // Nothing may be popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("queue underflow");

endmodule
